[design/stp_pkg.sv]
// Shared types and constants for the score table top-K roulette pick block.
// Holds item structs, function and status codes, and controller/datapath links.
// No dependencies.
package stp_pkg;

  // Default sizes
  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned AVOID_DEPTH_DEF = 16;
  localparam int unsigned TOP_COUNT_DEF   = 10;

  // Function codes
  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_AVOID = 2'd1;
  localparam logic [1:0] FN_PICK  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_FAILED     = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_AVOID_FULL = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        key;
    logic signed [31:0] delta;
    logic [15:0]        random;
  } in_t;

  typedef struct packed {
    logic [63:0] picked_key;
    logic [2:0]  status;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch;      // capture item, clear scan state
    logic       rd_tab;     // read table entry at entry index
    logic       wr_upd;     // saturating update of the read entry
    logic       wr_new;     // append the item key and delta
    logic       wr_avoid;   // append the item key to avoid list
    logic       clr_avoid;  // empty the avoid list
    logic       inc_i;
    logic       clr_j;
    logic       inc_j;
    logic       rd_av;      // read avoid entry at avoid index
    logic       ins;        // insert read entry into candidate list
    logic       clr_k;
    logic       inc_k;
    logic       acc_total;
    logic       mul;
    logic       acc_run;
    logic       emit;       // drive a result next cycle
    logic       emit_key;   // result carries candidate key k
    logic [2:0] emit_st;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic tab_empty;
    logic tab_full;
    logic i_last;
    logic key_hit;
    logic avoid_empty;
    logic avoid_full;
    logic j_last;
    logic avoid_hit;
    logic cand_none;
    logic k_last;
    logic run_hit;
  } sts_t;

endpackage

[design/stp_ctrl.sv]
// Controller state machine for the score table top-K roulette pick block.
// Depends on stp_pkg; drives stp_dp through cmd_t and reads sts_t.
module stp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    func,
  input  stp_pkg::sts_t sts,
  output stp_pkg::cmd_t cmd,
  output logic          busy
);
  import stp_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADD_RD  = 4'd1;
  localparam logic [3:0] S_ADD_CMP = 4'd2;
  localparam logic [3:0] S_ADD_NEW = 4'd3;
  localparam logic [3:0] S_AV_WR   = 4'd4;
  localparam logic [3:0] S_PK_RD   = 4'd5;
  localparam logic [3:0] S_PK_AVRD = 4'd6;
  localparam logic [3:0] S_PK_AVCM = 4'd7;
  localparam logic [3:0] S_PK_INS  = 4'd8;
  localparam logic [3:0] S_PK_SUM  = 4'd9;
  localparam logic [3:0] S_PK_MUL  = 4'd10;
  localparam logic [3:0] S_PK_RUN  = 4'd11;
  localparam logic [3:0] S_PK_CHK  = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          case (func)
            FN_ADD:   state_nxt = sts.tab_empty ? S_ADD_NEW : S_ADD_RD;
            FN_AVOID: state_nxt = S_AV_WR;
            FN_PICK: begin
              if (sts.tab_empty) begin
                cmd.emit      = 1'b1;
                cmd.emit_st   = ST_EMPTY;
                cmd.clr_avoid = 1'b1;
              end else begin
                state_nxt = S_PK_RD;
              end
            end
            default: begin
              cmd.emit    = 1'b1;
              cmd.emit_st = ST_OK;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        cmd.rd_tab = 1'b1;
        state_nxt  = S_ADD_CMP;
      end
      S_ADD_CMP: begin
        if (sts.key_hit) begin
          cmd.wr_upd  = 1'b1;
          cmd.emit    = 1'b1;
          cmd.emit_st = ST_OK;
          state_nxt   = S_IDLE;
        end else if (sts.i_last) begin
          state_nxt = S_ADD_NEW;
        end else begin
          cmd.inc_i = 1'b1;
          state_nxt = S_ADD_RD;
        end
      end
      S_ADD_NEW: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
        if (sts.tab_full) begin
          cmd.emit_st = ST_TABLE_FULL;
        end else begin
          cmd.wr_new  = 1'b1;
          cmd.emit_st = ST_OK;
        end
      end
      S_AV_WR: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
        if (sts.avoid_full) begin
          cmd.emit_st = ST_AVOID_FULL;
        end else begin
          cmd.wr_avoid = 1'b1;
          cmd.emit_st  = ST_OK;
        end
      end
      // scan table, checking each entry against the avoid list
      S_PK_RD: begin
        cmd.rd_tab = 1'b1;
        cmd.clr_j  = 1'b1;
        state_nxt  = sts.avoid_empty ? S_PK_INS : S_PK_AVRD;
      end
      S_PK_AVRD: begin
        cmd.rd_av = 1'b1;
        state_nxt = S_PK_AVCM;
      end
      S_PK_AVCM: begin
        if (sts.avoid_hit) begin
          if (sts.i_last) begin
            state_nxt = S_PK_CHK;
          end else begin
            cmd.inc_i = 1'b1;
            state_nxt = S_PK_RD;
          end
        end else if (sts.j_last) begin
          state_nxt = S_PK_INS;
        end else begin
          cmd.inc_j = 1'b1;
          state_nxt = S_PK_AVRD;
        end
      end
      S_PK_INS: begin
        cmd.ins = 1'b1;
        if (sts.i_last) begin
          state_nxt = S_PK_CHK;
        end else begin
          cmd.inc_i = 1'b1;
          state_nxt = S_PK_RD;
        end
      end
      S_PK_CHK: begin
        if (sts.cand_none) begin
          cmd.emit      = 1'b1;
          cmd.emit_st   = ST_FAILED;
          cmd.clr_avoid = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.clr_k = 1'b1;
          state_nxt = S_PK_SUM;
        end
      end
      // total of weights, one candidate a cycle
      S_PK_SUM: begin
        cmd.acc_total = 1'b1;
        if (sts.k_last) begin
          cmd.clr_k = 1'b1;
          state_nxt = S_PK_MUL;
        end else begin
          cmd.inc_k = 1'b1;
        end
      end
      S_PK_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_PK_RUN;
      end
      // running sum against threshold
      S_PK_RUN: begin
        cmd.acc_run = 1'b1;
        if (sts.run_hit) begin
          cmd.emit      = 1'b1;
          cmd.emit_key  = 1'b1;
          cmd.emit_st   = ST_OK;
          cmd.clr_avoid = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.k_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_st   = ST_FAILED;
          cmd.clr_avoid = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.inc_k = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/stp_dp.sv]
// Datapath for the score table top-K roulette pick block: table and avoid
// memories, scan counters, sorted candidate list and roulette arithmetic.
// Depends on stp_pkg; commanded by stp_ctrl.
module stp_dp #(
  parameter int unsigned TABLE_DEPTH = stp_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned AVOID_DEPTH = stp_pkg::AVOID_DEPTH_DEF,
  parameter int unsigned TOP_COUNT   = stp_pkg::TOP_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stp_pkg::in_t  in_data,
  input  stp_pkg::cmd_t cmd,
  output stp_pkg::sts_t sts,
  output logic          out_valid,
  output stp_pkg::out_t out_data
);
  import stp_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (AVOID_DEPTH > 1) ? $clog2(AVOID_DEPTH) : 1;
  localparam int VW = $clog2(AVOID_DEPTH + 1);
  localparam int KW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int NW = $clog2(TOP_COUNT + 1);
  localparam int TW = 33 + KW;          // weight sum
  localparam int PW = TW + 18;          // products

  // Memories
  logic [63:0]        key_mem   [TABLE_DEPTH];
  logic signed [31:0] score_mem [TABLE_DEPTH];
  logic [63:0]        avoid_mem [AVOID_DEPTH];

  in_t                item_r;
  logic [EW-1:0]      entry_cnt_r;
  logic [VW-1:0]      avoid_cnt_r;
  logic [IW-1:0]      i_r;
  logic [AW-1:0]      j_r;
  logic [KW-1:0]      k_r;
  logic [63:0]        key_q_r;
  logic signed [31:0] score_q_r;
  logic [63:0]        av_q_r;

  logic [63:0]        c_key_r   [TOP_COUNT];
  logic signed [31:0] c_score_r [TOP_COUNT];
  logic [NW-1:0]      cand_n_r;

  logic signed [TW-1:0] total_r, run_r;
  logic signed [PW-1:0] thr_r;
  logic                 out_valid_r;
  out_t                 out_r;

  // Saturating score update
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  always_comb begin
    sum_wide = {score_q_r[31], score_q_r} + {item_r.delta[31], item_r.delta};
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  // Candidate weights
  logic [KW-1:0]        last_k;
  logic signed [31:0]   c_min, c_max;
  logic signed [32:0]   w_k;
  always_comb begin
    last_k = KW'(cand_n_r - NW'(1));
    c_min  = c_score_r[last_k];
    c_max  = c_score_r[0];
    if (c_max != c_min) begin
      w_k = {c_score_r[k_r][31], c_score_r[k_r]} - {c_min[31], c_min};
    end else begin
      w_k = {c_score_r[k_r][31], c_score_r[k_r]};
    end
  end

  logic signed [TW-1:0] run_nxt;
  logic signed [PW-1:0] run_scaled;
  assign run_nxt    = run_r + TW'(w_k);
  assign run_scaled = (PW'(run_nxt) <<< 16) - PW'(run_nxt);

  // Sorted insertion: entries scoring at least the new one stay ahead
  logic [TOP_COUNT-1:0] ge;
  always_comb begin
    for (int n = 0; n < TOP_COUNT; n++) begin
      ge[n] = (NW'(n) < cand_n_r) && (c_score_r[n] >= score_q_r);
    end
  end

  // Status
  always_comb begin
    sts.tab_empty   = (entry_cnt_r == '0);
    sts.tab_full    = (entry_cnt_r >= EW'(TABLE_DEPTH));
    sts.i_last      = ({1'b0, i_r} + (IW+1)'(1)) >= (IW+1)'(entry_cnt_r);
    sts.key_hit     = (key_q_r == item_r.key);
    sts.avoid_empty = (avoid_cnt_r == '0);
    sts.avoid_full  = (avoid_cnt_r >= VW'(AVOID_DEPTH));
    sts.j_last      = ({1'b0, j_r} + (AW+1)'(1)) >= (AW+1)'(avoid_cnt_r);
    sts.avoid_hit   = (av_q_r == key_q_r);
    sts.cand_none   = (cand_n_r == '0);
    sts.k_last      = ({1'b0, k_r} + (KW+1)'(1)) >= (KW+1)'(cand_n_r);
    sts.run_hit     = (run_scaled >= thr_r);
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (cmd.rd_tab) begin
      key_q_r   <= key_mem[i_r];
      score_q_r <= score_mem[i_r];
    end
    if (cmd.wr_upd) begin
      score_mem[i_r] <= sum_sat;
    end
    if (cmd.wr_new) begin
      key_mem[entry_cnt_r[IW-1:0]]   <= item_r.key;
      score_mem[entry_cnt_r[IW-1:0]] <= item_r.delta;
    end
    if (cmd.rd_av) begin
      av_q_r <= avoid_mem[j_r];
    end
    if (cmd.wr_avoid) begin
      avoid_mem[avoid_cnt_r[AW-1:0]] <= item_r.key;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r  <= in_data;
      total_r <= '0;
      run_r   <= '0;
    end
    if (cmd.acc_total) begin
      total_r <= total_r + TW'(w_k);
    end
    if (cmd.mul) begin
      thr_r <= PW'(total_r) * $signed({1'b0, item_r.random});
    end
    if (cmd.acc_run) begin
      run_r <= run_nxt;
    end
    if (cmd.ins) begin
      for (int n = 0; n < TOP_COUNT; n++) begin
        if (!ge[n]) begin
          if (n == 0 || ge[(n == 0) ? 0 : n - 1]) begin
            c_key_r[n]   <= key_q_r;
            c_score_r[n] <= score_q_r;
          end else begin
            c_key_r[n]   <= c_key_r[(n == 0) ? 0 : n - 1];
            c_score_r[n] <= c_score_r[(n == 0) ? 0 : n - 1];
          end
        end
      end
    end
    if (cmd.emit) begin
      out_r.status     <= cmd.emit_st;
      out_r.picked_key <= cmd.emit_key ? c_key_r[k_r] : 64'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_cnt_r <= '0;
      avoid_cnt_r <= '0;
      cand_n_r    <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.wr_new) begin
        entry_cnt_r <= entry_cnt_r + EW'(1);
      end
      if (cmd.wr_avoid) begin
        avoid_cnt_r <= avoid_cnt_r + VW'(1);
      end else if (cmd.clr_avoid) begin
        avoid_cnt_r <= '0;
      end
      if (cmd.latch) begin
        i_r      <= '0;
        cand_n_r <= '0;
      end else if (cmd.inc_i) begin
        i_r <= i_r + IW'(1);
      end
      if (cmd.clr_j) begin
        j_r <= '0;
      end else if (cmd.inc_j) begin
        j_r <= j_r + AW'(1);
      end
      if (cmd.latch || cmd.clr_k) begin
        k_r <= '0;
      end else if (cmd.inc_k) begin
        k_r <= k_r + KW'(1);
      end
      if (cmd.ins && !ge[TOP_COUNT-1] && cand_n_r < NW'(TOP_COUNT)) begin
        cand_n_r <= cand_n_r + NW'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_cnt_r <= EW'(TABLE_DEPTH) && avoid_cnt_r <= VW'(AVOID_DEPTH))
    else $error("count beyond depth");
  a_cand_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cand_n_r <= NW'(TOP_COUNT))
    else $error("candidate count beyond top count");
  a_key_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.picked_key != 64'd0 |-> out_r.status == ST_OK)
    else $error("picked key with failing status");
  a_pick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.clr_avoid && !cmd.wr_avoid |=> avoid_cnt_r == '0)
    else $error("avoid list not cleared after pick");
`endif

endmodule

[design/score_table_topk_roulette_pick.sv]
// Top level of the score table top-K roulette pick block.
// Depends on stp_pkg, stp_ctrl and stp_dp.
//
// One item at a time: start is taken while busy is low, and every item gives
// exactly one result, shown for one cycle with out_valid; the receiver cannot
// stall it. An unused function code and a pick on an empty table never raise
// busy, so the next item can follow directly. An add reads and compares the
// table entries in turn, stopping at the entry that holds its key; if no entry
// holds it, it appends the item or reports a full table. A pick reads each
// table entry, compares it with each avoid entry (the compare stops early on
// an avoid hit) and inserts the entry into the candidate list when it is not
// avoided. If every entry is avoided it then reports a failure after the
// candidate check; else it goes through the candidate check, weight sum,
// threshold multiply, running-sum compare and result register.
module score_table_topk_roulette_pick #(
  parameter int unsigned TABLE_DEPTH = stp_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned AVOID_DEPTH = stp_pkg::AVOID_DEPTH_DEF,
  parameter int unsigned TOP_COUNT   = stp_pkg::TOP_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  stp_pkg::in_t  in_data,
  output logic          out_valid,
  output stp_pkg::out_t out_data
);
  import stp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  stp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Storage and arithmetic
  stp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AVOID_DEPTH (AVOID_DEPTH),
    .TOP_COUNT   (TOP_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[bench/tb_score_table_topk_roulette_pick.sv]
// Testbench for score_table_topk_roulette_pick: directed and random add, avoid and
// pick items, each result checked against a score-table predictor kept in the bench.
// Depends on stp_pkg and the score_table_topk_roulette_pick RTL.
module tb_score_table_topk_roulette_pick;
  import stp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_N = 256;
  localparam int AVD_N = 16;
  localparam int TOP_N = 10;

  // Function code with no operation behind it
  localparam logic [1:0] FN_UNUSED = 2'd3;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  in_t   in_data = '0;
  logic  out_valid;
  out_t  out_data;

  score_table_topk_roulette_pick dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the score table and avoid list
  logic [63:0]        tbl_key [TBL_N];
  logic signed [31:0] tbl_score [TBL_N];
  int                 tbl_cnt = 0;
  logic [63:0]        avd_key [AVD_N];
  int                 avd_cnt = 0;

  in_t  pending_items[$];
  out_t expected_results[$];
  int   errors = 0;
  bit   stim_done = 0;

  function automatic bit key_avoided(logic [63:0] k);
    for (int i = 0; i < avd_cnt; i++) if (avd_key[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  // Roulette over the best TOP_N non-avoided entries
  function automatic out_t pick_roulette(logic [15:0] rnd);
    out_t        r;
    bit          used [TBL_N];
    logic [63:0] ck [TOP_N];
    longint      cs [TOP_N];
    int          n, best;
    bit          found;
    longint      mn, mx, total, run;
    r = '0;
    n = 0;
    mn = 0; mx = 0; total = 0; run = 0;
    r.status = ST_OK;
    if (tbl_cnt == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    for (int i = 0; i < TBL_N; i++) used[i] = 1'b0;
    for (int s = 0; s < TOP_N; s++) begin
      found = 0;
      best = 0;
      for (int i = 0; i < tbl_cnt; i++) begin
        if (used[i] || key_avoided(tbl_key[i])) continue;
        if (!found || tbl_score[i] > tbl_score[best]) begin
          best = i;
          found = 1;
        end
      end
      if (!found) break;
      used[best] = 1'b1;
      ck[n] = tbl_key[best];
      cs[n] = longint'(tbl_score[best]);
      if (n == 0 || cs[n] < mn) mn = cs[n];
      if (n == 0 || cs[n] > mx) mx = cs[n];
      n++;
    end
    if (n == 0) begin
      r.status = ST_FAILED;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      if (mx != mn) cs[i] -= mn;
      total += cs[i];
    end
    for (int i = 0; i < n; i++) begin
      run += cs[i];
      if (run * 65535 >= total * longint'(rnd)) begin
        r.picked_key = ck[i];
        return r;
      end
    end
    r.status = ST_FAILED;
    return r;
  endfunction

  // Expected result of one item; updates the shadow state
  function automatic out_t score_table_step(in_t it);
    out_t   r;
    longint sum;
    bit     hit;
    r = '0;
    r.status = ST_OK;
    hit = 0;
    case (it.func)
      FN_ADD: begin
        for (int i = 0; i < tbl_cnt && !hit; i++) begin
          if (tbl_key[i] == it.key) begin
            sum = longint'(tbl_score[i]) + longint'(it.delta);
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            tbl_score[i] = sum[31:0];
            hit = 1;
          end
        end
        if (!hit) begin
          if (tbl_cnt >= TBL_N) begin
            r.status = ST_TABLE_FULL;
          end else begin
            tbl_key[tbl_cnt] = it.key;
            tbl_score[tbl_cnt] = it.delta;
            tbl_cnt++;
          end
        end
      end
      FN_AVOID: begin
        if (avd_cnt >= AVD_N) begin
          r.status = ST_AVOID_FULL;
        end else begin
          avd_key[avd_cnt] = it.key;
          avd_cnt++;
        end
      end
      FN_PICK: begin
        r = pick_roulette(it.random);
        avd_cnt = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: new item or idle gap at each falling edge once the last one was taken
  int  gap_left = 0;
  bit  taken_last = 0;
  always @(negedge clk) begin
    if (rst_n && (!start || taken_last)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        start <= 1'b1;
        if (pending_items.size() > 100 && $urandom_range(0, 7) == 0)
          gap_left <= $urandom_range(1, 16);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results, then predict for an item taken at this edge
  always @(posedge clk) begin
    out_t exp_r;
    taken_last <= 1'b0;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: picked_key %h status %0d",
               out_data.picked_key, out_data.status);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.picked_key !== exp_r.picked_key) begin
          $error("picked_key expected %h actual %h", exp_r.picked_key,
                 out_data.picked_key);
          errors++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data.status);
          errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      expected_results.push_back(score_table_step(in_data));
      taken_last <= 1'b1;
    end
  end

  function automatic in_t mk(logic [1:0] f, logic [63:0] k, logic [31:0] d,
                             logic [15:0] rnd);
    in_t it;
    it.func = f;
    it.key = k;
    it.delta = d;
    it.random = rnd;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Stimulus
  logic [63:0] key_pool [24];
  initial begin
    int sel;
    logic [31:0] d;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 24; i++) key_pool[i] = rand64();

    // Directed: empty pick, equal negative scores, saturation, ties, full avoid list
    pending_items.push_back(mk(FN_PICK, '0, '0, 16'd100));
    pending_items.push_back(mk(FN_ADD, 64'h11, -32'sd5, '0));
    pending_items.push_back(mk(FN_PICK, '0, '0, 16'd0));
    pending_items.push_back(mk(FN_PICK, '1, '1, 16'hFFFF));
    pending_items.push_back(mk(FN_ADD, '1, 32'h7FFF_FFFF, '0));
    pending_items.push_back(mk(FN_ADD, '1, 32'h7FFF_FFFF, '1));
    pending_items.push_back(mk(FN_ADD, '0, 32'h8000_0000, '0));
    pending_items.push_back(mk(FN_ADD, '0, -32'sd1, '0));
    pending_items.push_back(mk(FN_ADD, 64'h22, 32'd0, '0));
    pending_items.push_back(mk(FN_ADD, 64'h33, 32'd0, '0));
    pending_items.push_back(mk(FN_PICK, '0, '0, 16'hFFFF));
    pending_items.push_back(mk(FN_UNUSED, '1, '1, '1));
    for (int i = 0; i < 17; i++)
      pending_items.push_back(mk(FN_AVOID, (i < 5) ? key_pool[i] :
                                 (i == 5 ? 64'h11 : (i == 6 ? 64'h22 : 64'h33)),
                                 '0, '0));
    pending_items.push_back(mk(FN_PICK, '0, '0, 16'd1));

    // Random: mostly keys from a small pool so adds hit existing entries
    for (int n = 0; n < 160; n++) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: d = $urandom();
        1: d = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
        2: d = $urandom_range(0, 6) - 3;
        default: d = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
      if (sel < 45)
        pending_items.push_back(mk(FN_ADD, key_pool[$urandom_range(0, 23)], d,
                                   16'($urandom())));
      else if (sel < 68)
        pending_items.push_back(mk(FN_AVOID, key_pool[$urandom_range(0, 23)],
                                   $urandom(), 16'($urandom())));
      else if (sel < 95)
        pending_items.push_back(mk(FN_PICK, rand64(), $urandom(),
                                   ($urandom_range(0, 5) == 0) ?
                                   (($urandom_range(0, 1)) ? 16'hFFFF : 16'h0) :
                                   16'($urandom())));
      else
        pending_items.push_back(mk(FN_UNUSED, rand64(), $urandom(),
                                   16'($urandom())));
    end

    // Fill the table, then overflow it and pick over a full table
    for (int n = 0; n < 260; n++)
      pending_items.push_back(mk(FN_ADD, rand64(), $urandom(), 16'($urandom())));
    pending_items.push_back(mk(FN_ADD, key_pool[3], 32'd7, '0));
    pending_items.push_back(mk(FN_AVOID, key_pool[3], '0, '0));
    pending_items.push_back(mk(FN_PICK, '0, '0, 16'd30000));
    pending_items.push_back(mk(FN_PICK, '0, '0, 16'hFFFF));

    // Reset
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Drain
    while (pending_items.size() != 0) @(posedge clk);
    @(posedge clk);
    while (start || expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
design/stp_pkg.sv
design/stp_ctrl.sv
design/stp_dp.sv
design/score_table_topk_roulette_pick.sv
bench/tb_score_table_topk_roulette_pick.sv
